// ===== src/bmu_pkg.sv =====
// Package for the bitmap 2x upscaler: register indexes, field widths,
// controller state type and the pixel doubling function.
// Depends on nothing; every other file of the block but bmu_res_if uses it.
`timescale 1ns / 1ps

package bmu_pkg;

  localparam int SRC_W        = 8;
  localparam int ROW_BYTES_W  = 5;
  localparam int IMAGE_ROWS_W = 9;
  localparam int ROW_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 9;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_ROWS = 1'd1;

  localparam logic [ROW_BYTES_W-1:0]  ROW_BYTES_RESET  = 5'd2;
  localparam logic [IMAGE_ROWS_W-1:0] IMAGE_ROWS_RESET = 9'd16;
  localparam logic [IMAGE_ROWS_W-1:0] IMAGE_ROWS_MAX   = 9'd256;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HI   = 5'b00010,
    S_LO   = 5'b00100,
    S_RHI  = 5'b01000,
    S_RLO  = 5'b10000
  } state_t;

  function automatic logic [7:0] double_nibble(input logic [3:0] n);
    logic [7:0] r;
    r = {n[3], n[3], n[2], n[2], n[1], n[1], n[0], n[0]};
    return r;
  endfunction

endpackage

// ===== src/bmu_src_if.sv =====
// Request channel that carries source bytes into the upscaler.
// Depends on bmu_pkg for the field width.
`timescale 1ns / 1ps

interface bmu_src_if;
  logic                       valid;
  logic                       ready;
  logic [bmu_pkg::SRC_W-1:0]  src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink (input valid, input src_byte, output ready);
endinterface

// ===== src/bmu_res_if.sv =====
// Request channel that carries upscaled result bytes out of the upscaler.
// Depends on nothing beyond its own fields.
`timescale 1ns / 1ps

interface bmu_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       repeat_copy;
  logic       last_of_run;
  logic       image_done;

  modport source (output valid, output out_byte, output repeat_copy,
                  output last_of_run, output image_done, input ready);
  modport sink (input valid, input out_byte, input repeat_copy,
                input last_of_run, input image_done, output ready);
endinterface

// ===== src/bmu_line_store.sv =====
// Line store of the upscaler: one row of source bytes in a synchronous
// memory with one write port and one registered read port.
// Depends on bmu_pkg for the byte width.
`timescale 1ns / 1ps

module bmu_line_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bmu_pkg::SRC_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [bmu_pkg::SRC_W-1:0] rd_data
);

  logic [bmu_pkg::SRC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/bitmap_2x_upscaler.sv =====
// Bitmap 2x upscaler top level: configuration registers, row and column
// counters, the controller and the output register. Uses bmu_pkg,
// bmu_src_if, bmu_res_if and bmu_line_store.
`timescale 1ns / 1ps

// The block doubles a one-bit-per-pixel bitmap in both directions. A source
// byte is taken only while the block is idle; its two result bytes follow at
// one per cycle while the output register is free. The last byte of a row is
// followed by the whole row again, read back from the line store, which adds
// two result bytes per source byte of the row, one per cycle while the output
// register is free. The single output register sets this pace, and a result
// that is not taken holds the block. The user must write configuration only
// while no request is in progress; the block itself does not enforce it.
module bitmap_2x_upscaler #(
  parameter int MAX_ROW_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bmu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bmu_pkg::CFG_DATA_W-1:0]  cfg_data,
  bmu_src_if.sink                         src,
  bmu_res_if.source                       res
);

  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam logic [bmu_pkg::ROW_BYTES_W-1:0] MAX_RB = bmu_pkg::ROW_BYTES_W'(MAX_ROW_BYTES);

  logic [bmu_pkg::ROW_BYTES_W-1:0]  row_bytes;
  logic [bmu_pkg::IMAGE_ROWS_W-1:0] image_rows;
  logic [bmu_pkg::ROW_BYTES_W-1:0]  rb_eff;
  logic [bmu_pkg::IMAGE_ROWS_W-1:0] rows_eff;

  bmu_pkg::state_t state, state_next;
  logic [CW-1:0]                    col, col_next;
  logic [bmu_pkg::ROW_INDEX_W-1:0]  row, row_next;
  logic [CW-1:0]                    idx, idx_next;
  logic [bmu_pkg::SRC_W-1:0]        hold;
  logic                             end_row_q;
  logic                             end_img_q;
  logic                             end_row;
  logic                             end_img;
  logic                             fin;
  logic                             accept;
  logic                             free;
  logic [bmu_pkg::SRC_W-1:0]        rd_data;

  logic       ld;
  logic [7:0] ld_byte;
  logic       ld_rep;
  logic       ld_last;
  logic       ld_done;

  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_rep;
  logic       res_last;
  logic       res_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes  <= bmu_pkg::ROW_BYTES_RESET;
      image_rows <= bmu_pkg::IMAGE_ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bmu_pkg::CFG_ROW_BYTES: begin
          row_bytes <= cfg_data[bmu_pkg::ROW_BYTES_W-1:0];
        end
        bmu_pkg::CFG_IMAGE_ROWS: begin
          image_rows <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (row_bytes == '0) begin
      rb_eff = bmu_pkg::ROW_BYTES_W'(1);
    end else if (row_bytes > MAX_RB) begin
      rb_eff = MAX_RB;
    end else begin
      rb_eff = row_bytes;
    end
    if (image_rows == '0) begin
      rows_eff = bmu_pkg::IMAGE_ROWS_W'(1);
    end else if (image_rows > bmu_pkg::IMAGE_ROWS_MAX) begin
      rows_eff = bmu_pkg::IMAGE_ROWS_MAX;
    end else begin
      rows_eff = image_rows;
    end
  end

  assign end_row = bmu_pkg::ROW_BYTES_W'(col) >= (rb_eff - bmu_pkg::ROW_BYTES_W'(1));
  assign end_img = end_row &&
                   (bmu_pkg::IMAGE_ROWS_W'(row) >= (rows_eff - bmu_pkg::IMAGE_ROWS_W'(1)));
  assign fin     = bmu_pkg::ROW_BYTES_W'(idx) == (rb_eff - bmu_pkg::ROW_BYTES_W'(1));

  assign src.ready = (state == bmu_pkg::S_IDLE);
  assign accept    = src.valid && src.ready;
  assign free      = !res_valid || res.ready;

  bmu_line_store #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data (src.src_byte),
    .rd_addr (idx_next),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    col_next   = col;
    row_next   = row;
    idx_next   = idx;
    ld         = 1'b0;
    ld_byte    = bmu_pkg::double_nibble(hold[7:4]);
    ld_rep     = 1'b0;
    ld_last    = 1'b0;
    ld_done    = 1'b0;
    case (state)
      bmu_pkg::S_IDLE: begin
        if (src.valid) begin
          state_next = bmu_pkg::S_HI;
        end
      end
      bmu_pkg::S_HI: begin
        if (free) begin
          ld         = 1'b1;
          state_next = bmu_pkg::S_LO;
        end
      end
      bmu_pkg::S_LO: begin
        ld_byte = bmu_pkg::double_nibble(hold[3:0]);
        ld_last = !end_row_q;
        if (free) begin
          ld = 1'b1;
          if (end_row_q) begin
            idx_next   = '0;
            state_next = bmu_pkg::S_RHI;
          end else begin
            col_next   = col + CW'(1);
            state_next = bmu_pkg::S_IDLE;
          end
        end
      end
      bmu_pkg::S_RHI: begin
        ld_byte = bmu_pkg::double_nibble(rd_data[7:4]);
        ld_rep  = 1'b1;
        if (free) begin
          ld         = 1'b1;
          state_next = bmu_pkg::S_RLO;
        end
      end
      bmu_pkg::S_RLO: begin
        ld_byte = bmu_pkg::double_nibble(rd_data[3:0]);
        ld_rep  = 1'b1;
        ld_last = fin;
        ld_done = fin && end_img_q;
        if (free) begin
          ld = 1'b1;
          if (fin) begin
            col_next   = '0;
            row_next   = end_img_q ? '0 : row + bmu_pkg::ROW_INDEX_W'(1);
            state_next = bmu_pkg::S_IDLE;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = bmu_pkg::S_RHI;
          end
        end
      end
      default: begin
        state_next = bmu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmu_pkg::S_IDLE;
      col       <= '0;
      row       <= '0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      idx   <= idx_next;
      if (ld) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold      <= src.src_byte;
      end_row_q <= end_row;
      end_img_q <= end_img;
    end
    if (ld) begin
      res_byte <= ld_byte;
      res_rep  <= ld_rep;
      res_last <= ld_last;
      res_done <= ld_done;
    end
  end

  assign res.valid       = res_valid;
  assign res.out_byte    = res_byte;
  assign res.repeat_copy = res_rep;
  assign res.last_of_run = res_last;
  assign res.image_done  = res_done;

endmodule

// ===== tb/upscale_checker.sv =====
// Checker for the bitmap 2x upscaler: watches the configuration port and both
// request channels, predicts every result byte and compares it with the block.
// Depends on bmu_pkg, bmu_src_if and bmu_res_if.
`timescale 1ns / 1ps

module upscale_checker #(
  parameter int MAX_ROW_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bmu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bmu_pkg::CFG_DATA_W-1:0]  cfg_data,
  bmu_src_if                              src,
  bmu_res_if                              res,
  output int                              pending_count,
  output int                              fail_count
);
  import bmu_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       repeat_copy;
    logic       last_of_run;
    logic       image_done;
  } upscaled_t;

  upscaled_t                expected_bytes[$];
  logic [7:0]               line_copy[MAX_ROW_BYTES];
  int                       col_pos;
  logic [ROW_INDEX_W-1:0]   row_pos;
  logic [ROW_BYTES_W-1:0]   row_bytes_cfg;
  logic [IMAGE_ROWS_W-1:0]  image_rows_cfg;
  int                       fails;

  initial begin
    fails         = 0;
    pending_count = 0;
    fail_count    = 0;
  end

  function automatic logic [7:0] widen_nibble(input logic [3:0] n);
    logic [7:0] w;
    for (int k = 0; k < 4; k++) begin
      w[2*k]   = n[k];
      w[2*k+1] = n[k];
    end
    return w;
  endfunction

  task automatic upscale_byte(input logic [7:0] pixels);
    int         rb_eff;
    int         rows_eff;
    int         col;
    bit         end_row;
    bit         end_img;
    logic [7:0] s;
    rb_eff   = (row_bytes_cfg == 0) ? 1 :
               (row_bytes_cfg > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(row_bytes_cfg);
    rows_eff = (image_rows_cfg == 0) ? 1 :
               (image_rows_cfg > IMAGE_ROWS_MAX) ? int'(IMAGE_ROWS_MAX) : int'(image_rows_cfg);
    col      = (col_pos >= MAX_ROW_BYTES) ? MAX_ROW_BYTES - 1 : col_pos;
    line_copy[col] = pixels;
    end_row  = (col >= rb_eff - 1);
    end_img  = end_row && (int'(row_pos) >= rows_eff - 1);
    expected_bytes.push_back(upscaled_t'{widen_nibble(pixels[7:4]), 1'b0, 1'b0, 1'b0});
    expected_bytes.push_back(upscaled_t'{widen_nibble(pixels[3:0]), 1'b0, !end_row, 1'b0});
    if (!end_row) begin
      col_pos = col + 1;
    end else begin
      for (int i = 0; i < rb_eff; i++) begin
        s = line_copy[i];
        expected_bytes.push_back(upscaled_t'{widen_nibble(s[7:4]), 1'b1, 1'b0, 1'b0});
        expected_bytes.push_back(upscaled_t'{widen_nibble(s[3:0]), 1'b1, i == rb_eff - 1,
                                             (i == rb_eff - 1) && end_img});
      end
      col_pos = 0;
      row_pos = end_img ? '0 : row_pos + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    upscaled_t got;
    upscaled_t want;
    if (rst) begin
      expected_bytes.delete();
      col_pos        = 0;
      row_pos        = '0;
      row_bytes_cfg  = ROW_BYTES_RESET;
      image_rows_cfg = IMAGE_ROWS_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_BYTES:  row_bytes_cfg  = cfg_data[ROW_BYTES_W-1:0];
          CFG_IMAGE_ROWS: image_rows_cfg = cfg_data[IMAGE_ROWS_W-1:0];
          default: ;
        endcase
      end
      if (src.valid && src.ready) begin
        upscale_byte(src.src_byte);
      end
      if (res.valid && res.ready) begin
        got = upscaled_t'{res.out_byte, res.repeat_copy, res.last_of_run, res.image_done};
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %h rep %b last %b done %b",
                   $time, got.out_byte, got.repeat_copy, got.last_of_run, got.image_done);
          fails++;
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected byte %h rep %b last %b done %b, actual byte %h rep %b last %b done %b",
                     $time, want.out_byte, want.repeat_copy, want.last_of_run, want.image_done,
                     got.out_byte, got.repeat_copy, got.last_of_run, got.image_done);
            fails++;
          end
        end
      end
    end
    pending_count <= expected_bytes.size();
    fail_count    <= fails;
  end

endmodule

// ===== tb/tb_bitmap_2x_upscaler.sv =====
// Top of the bitmap 2x upscaler testbench: clock, reset, configuration writes,
// source requests with bursts and gaps, result back-pressure and the verdict.
// Depends on bmu_pkg, both channel interfaces, the block and upscale_checker.
`timescale 1ns / 1ps

module tb_bitmap_2x_upscaler;
  import bmu_pkg::*;

  localparam int MAX_ROW_BYTES = 16;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_CADENCE} stall_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     pending_count;
  int                     fail_count;
  int                     cycles      = 0;
  int                     burst_left  = 0;
  int                     stall_left  = 0;
  int                     stall_tick  = 0;
  stall_mode_t            stall_mode  = READY_ALWAYS;
  logic [4:0]             cur_rb      = ROW_BYTES_RESET;

  bmu_src_if src_ch();
  bmu_res_if res_ch();

  bitmap_2x_upscaler #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .src      (src_ch),
    .res      (res_ch)
  );

  upscale_checker #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .src          (src_ch),
    .res          (res_ch),
    .pending_count(pending_count),
    .fail_count   (fail_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bitmap_2x_upscaler test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      READY_ALWAYS: res_ch.ready <= 1'b1;
      READY_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
      default:      res_ch.ready <= (stall_tick % 5 < 3);
    endcase
  end

  function automatic logic [7:0] rand_pixels();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] pixels);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        src_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    src_ch.valid    <= 1'b1;
    src_ch.src_byte <= pixels;
    @(posedge clk);
    while (!src_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    src_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input bit do_rb, input logic [4:0] rb,
                            input bit do_rows, input logic [8:0] rows);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    if (do_rb) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_ROW_BYTES;
      cfg_data  <= {junk, rb};
      cur_rb     = rb;
      @(posedge clk);
    end
    if (do_rows) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IMAGE_ROWS;
      cfg_data  <= rows;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] corner_bytes[8];
    int         sent;
    int         phase_len;
    int         rb_eff;
    logic [4:0] rb_pick;
    logic [8:0] rows_pick;
    corner_bytes    = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hA5, 8'h5A, 8'hF0, 8'h0F};
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_ROW_BYTES;
    cfg_data        = '0;
    src_ch.valid    = 1'b0;
    src_ch.src_byte = '0;
    res_ch.ready    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_bytes[i]) push_byte(corner_bytes[i]);
    wait_drained();
    set_config(1'b1, 5'd0, 1'b1, 9'd0);
    push_byte(8'h3C);
    push_byte(8'hC3);
    wait_drained();
    set_config(1'b1, 5'd3, 1'b1, 9'd2);
    push_byte(8'h11);
    push_byte(8'h22);
    wait_drained();
    // The row shrinks under the current column, so this request ends the row.
    set_config(1'b1, 5'd1, 1'b0, 9'd0);
    push_byte(8'h44);
    wait_drained();
    // The image shrinks under the current row, so this request ends the image.
    set_config(1'b0, 5'd0, 1'b1, 9'd1);
    push_byte(8'h88);
    wait_drained();

    // One-byte rows in the largest image, so the row counter runs to its end.
    set_config(1'b1, 5'd1, 1'b1, 9'd511);
    repeat (260) push_byte(rand_pixels());
    wait_drained();
    set_config(1'b1, 5'd31, 1'b1, 9'd256);
    repeat (40) push_byte(rand_pixels());
    wait_drained();

    sent = 0;
    while (sent < 180) begin
      case ($urandom_range(0, 9))
        0:       rb_pick = 5'd0;
        1:       rb_pick = 5'd16;
        2:       rb_pick = 5'd31;
        3:       rb_pick = 5'($urandom_range(17, 30));
        default: rb_pick = 5'($urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 9))
        0:       rows_pick = 9'd0;
        1:       rows_pick = 9'd1;
        2:       rows_pick = 9'd256;
        3:       rows_pick = 9'($urandom_range(257, 511));
        default: rows_pick = 9'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 3))
        0:       ;
        1:       set_config(1'b1, rb_pick, 1'b0, rows_pick);
        2:       set_config(1'b0, rb_pick, 1'b1, rows_pick);
        default: set_config(1'b1, rb_pick, 1'b1, rows_pick);
      endcase
      rb_eff    = (cur_rb == 0) ? 1 : (cur_rb > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(cur_rb);
      phase_len = (rb_eff >= 8) ? $urandom_range(16, 40) : $urandom_range(1, 24);
      repeat (phase_len) push_byte(rand_pixels());
      sent += phase_len;
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("bitmap_2x_upscaler test passed");
    end else begin
      $display("bitmap_2x_upscaler test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bmu_pkg.sv
src/bmu_src_if.sv
src/bmu_res_if.sv
src/bmu_line_store.sv
src/bitmap_2x_upscaler.sv
tb/upscale_checker.sv
tb/tb_bitmap_2x_upscaler.sv
